>>> rtl/azel_pkg.sv
// Shared types and codes for the azimuth/elevation sweep sequencer.
`timescale 1ns / 1ps

package azel_pkg;

  // event kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  // motor commands
  localparam logic [1:0] MOVE_NONE  = 2'd0;
  localparam logic [1:0] MOVE_TO    = 2'd1;
  localparam logic [1:0] MOVE_BY    = 2'd2;
  localparam logic [1:0] MOVE_RESET = 2'd3;

  // report codes
  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_MEAS = 2'd1;
  localparam logic [1:0] REP_DONE = 2'd2;

  // sweep types
  localparam logic [1:0] SWEEP_FULL = 2'd0;
  localparam logic [1:0] SWEEP_AZ   = 2'd1;
  localparam logic [1:0] SWEEP_EL   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_SWEEP_TYPE = 3'd0;
  localparam logic [2:0] REG_SPP        = 3'd1;
  localparam logic [2:0] REG_AZ_MIN     = 3'd2;
  localparam logic [2:0] REG_AZ_MAX     = 3'd3;
  localparam logic [2:0] REG_AZ_STEP    = 3'd4;
  localparam logic [2:0] REG_EL_MIN     = 3'd5;
  localparam logic [2:0] REG_EL_MAX     = 3'd6;
  localparam logic [2:0] REG_EL_STEP    = 3'd7;

  // register reset values
  localparam logic [7:0]         SPP_RESET     = 8'd5;
  localparam logic signed [29:0] AZ_MAX_RESET  = 30'sd359;
  localparam logic [28:0]        AZ_STEP_RESET = 29'd45000000;
  localparam logic signed [29:0] EL_MAX_RESET  = 30'sd90;
  localparam logic [28:0]        EL_STEP_RESET = 29'd18000000;

  typedef struct packed {
    logic [1:0]         sweep_type;
    logic [7:0]         samples_per_point;
    logic signed [29:0] az_min;
    logic signed [29:0] az_max;
    logic [28:0]        az_step;
    logic signed [29:0] el_min;
    logic signed [29:0] el_max;
    logic [28:0]        el_step;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        last_sample_time;
    logic [7:0]         sample_count;
    logic               az_done;
    logic               el_done;
    logic               all_done;
    logic signed [29:0] last_az;
    logic signed [29:0] last_el;
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        now_ms;
    logic signed [15:0] power_sample;
    logic [29:0]        az_swept;
    logic [29:0]        el_swept;
    logic signed [29:0] az_position;
    logic signed [29:0] el_position;
  } event_t;

  typedef struct packed {
    logic [1:0]         az_move;
    logic signed [30:0] az_target;
    logic               az_clear_swept;
    logic [1:0]         el_move;
    logic signed [29:0] el_target;
    logic               el_clear_swept;
    logic [1:0]         report;
    logic [31:0]        stamp_ms;
    logic [7:0]         sample_index;
    logic signed [15:0] power_out;
    logic signed [29:0] az_report;
    logic signed [29:0] el_report;
  } result_t;

endpackage

>>> rtl/azel_core.sv
// Next-state and result logic for one sequencer event.
`timescale 1ns / 1ps

module azel_core #(
  parameter int unsigned PERIOD_MS = 100
) (
  input  azel_pkg::cfg_t    cfg,
  input  azel_pkg::state_t  st,
  input  azel_pkg::event_t  ev,
  output azel_pkg::state_t  st_next,
  output azel_pkg::result_t res,
  output logic              has_result
);
  import azel_pkg::*;

  localparam logic [31:0] PERIOD = 32'(PERIOD_MS);

  logic [31:0]        elapsed;
  logic               early;
  logic               moving;
  logic               do_az;
  logic               do_el;
  logic signed [30:0] az_diff;
  logic signed [30:0] az_abs;
  logic [29:0]        az_span;
  logic signed [30:0] el_diff;
  logic signed [30:0] el_abs;
  logic [29:0]        el_span;
  logic signed [30:0] az_sum;
  logic signed [29:0] az_next;
  logic signed [30:0] el_sub;
  logic signed [29:0] el_next;
  logic               finished;

  assign elapsed = ev.now_ms - st.last_sample_time;
  assign early   = elapsed < PERIOD;
  assign moving  = st.sample_count >= cfg.samples_per_point;
  assign do_az   = (cfg.sweep_type == SWEEP_FULL) || (cfg.sweep_type == SWEEP_AZ);
  assign do_el   = (cfg.sweep_type == SWEEP_FULL) || (cfg.sweep_type == SWEEP_EL);

  // travel of each axis as a magnitude
  assign az_diff = 31'(cfg.az_max) - 31'(cfg.az_min);
  assign az_abs  = az_diff[30] ? -az_diff : az_diff;
  assign az_span = az_abs[29:0];
  assign el_diff = 31'(cfg.el_max) - 31'(cfg.el_min);
  assign el_abs  = el_diff[30] ? -el_diff : el_diff;
  assign el_span = el_abs[29:0];

  // azimuth steps up clamped at max, elevation down clamped at min
  assign az_sum  = 31'(st.last_az) + $signed({2'b00, cfg.az_step});
  assign az_next = (az_sum > 31'(cfg.az_max)) ? cfg.az_max : az_sum[29:0];
  assign el_sub  = 31'(st.last_el) - $signed({2'b00, cfg.el_step});
  assign el_next = (el_sub < 31'(cfg.el_min)) ? cfg.el_min : el_sub[29:0];

  always_comb begin
    st_next    = st;
    res        = '0;
    has_result = 1'b0;
    finished   = 1'b0;
    case (ev.kind)
      KIND_RESET: begin
        has_result       = 1'b1;
        res.az_move      = MOVE_RESET;
        res.el_move      = MOVE_RESET;
        st_next.az_done  = 1'b0;
        st_next.el_done  = 1'b0;
        st_next.all_done = 1'b0;
      end
      KIND_START: begin
        has_result         = 1'b1;
        res.az_move        = MOVE_TO;
        res.az_target      = 31'(cfg.az_min);
        res.az_clear_swept = 1'b1;
        res.el_move        = MOVE_TO;
        res.el_target      = cfg.el_max;
        res.el_clear_swept = 1'b1;
        st_next.last_az    = cfg.az_min;
        st_next.last_el    = cfg.el_max;
        st_next.az_done    = 1'b0;
        st_next.el_done    = 1'b0;
        st_next.all_done   = 1'b0;
      end
      KIND_TICK: begin
        if (!early) begin
          has_result = 1'b1;
          if (moving) begin
            st_next.sample_count = '0;
            if (do_az) begin
              if (ev.az_swept < az_span) begin
                res.az_move     = MOVE_TO;
                res.az_target   = 31'(az_next);
                st_next.last_az = az_next;
              end else begin
                // travel covered: unwind by the swept amount
                res.az_move        = MOVE_BY;
                res.az_target      = -$signed({1'b0, ev.az_swept});
                res.az_clear_swept = 1'b1;
                st_next.az_done    = 1'b1;
                st_next.last_az    = cfg.az_min;
              end
            end
            if (do_el && ((cfg.sweep_type == SWEEP_EL) || st_next.az_done)) begin
              if (ev.el_swept < el_span) begin
                res.el_move     = MOVE_TO;
                res.el_target   = el_next;
                st_next.last_el = el_next;
                st_next.az_done = 1'b0;
              end else begin
                res.el_move        = MOVE_TO;
                res.el_target      = cfg.el_max;
                res.el_clear_swept = 1'b1;
                st_next.el_done    = 1'b1;
                st_next.last_el    = cfg.el_max;
              end
            end
            case (cfg.sweep_type)
              SWEEP_FULL: st_next.all_done = st_next.el_done & st_next.az_done;
              SWEEP_AZ:   st_next.all_done = st_next.az_done;
              SWEEP_EL:   st_next.all_done = st_next.el_done;
              default:    st_next.all_done = st.all_done;
            endcase
            finished = st_next.all_done;
          end
          res.stamp_ms = ev.now_ms;
          if (finished) begin
            res.report = REP_DONE;
          end else begin
            st_next.sample_count     = st_next.sample_count + 8'd1;
            st_next.last_sample_time = ev.now_ms;
            res.report               = REP_MEAS;
            res.sample_index         = st_next.sample_count;
            res.power_out            = ev.power_sample;
            res.az_report            = ev.az_position;
            res.el_report            = ev.el_position;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/az_el_measurement_sweep_sequencer.sv
// Top level: sweep sequencer with event input register and result register.
// A result passes through the event input register and then the result register before it is presented.
// Throughput: one event per cycle while the result channel does not stall; state feedback closes through azel_core.
// Events that give no result (early tick, unused kind) still pass through the event input register.
// Reset (rst, synchronous) clears the stages, the sweep state and restores
// the register defaults.
`timescale 1ns / 1ps

module az_el_measurement_sweep_sequencer #(
  parameter int unsigned PERIOD_MS = 100
) (
  input  logic         clk,
  input  logic         rst,
  // event channel
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: now_ms, power_sample, az_swept, el_swept, az_position, el_position
  input  logic [167:0] s_tdata,
  // tuser: kind
  input  logic [1:0]   s_tuser,
  // result channel
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: az_move, az_target, az_clear_swept, el_move, el_target,
  //        el_clear_swept, stamp_ms, sample_index, power_out, az_report,
  //        el_report, one zero pad bit
  output logic [183:0] m_tdata,
  // tuser: report
  output logic [1:0]   m_tuser,
  // configuration
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [29:0]  cfg_data
);
  import azel_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  event_t  ev_in;
  event_t  ev;
  logic    in_valid;
  result_t res;
  result_t out_res;
  logic    has_result;
  logic    out_valid;
  logic    advance;

  assign ev_in.kind         = s_tuser;
  assign ev_in.now_ms       = s_tdata[31:0];
  assign ev_in.power_sample = s_tdata[47:32];
  assign ev_in.az_swept     = s_tdata[77:48];
  assign ev_in.el_swept     = s_tdata[107:78];
  assign ev_in.az_position  = s_tdata[137:108];
  assign ev_in.el_position  = s_tdata[167:138];

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  azel_core #(
    .PERIOD_MS (PERIOD_MS)
  ) u_core (
    .cfg        (cfg),
    .st         (st),
    .ev         (ev),
    .st_next    (st_next),
    .res        (res),
    .has_result (has_result)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sweep_type        <= SWEEP_FULL;
      cfg.samples_per_point <= SPP_RESET;
      cfg.az_min            <= '0;
      cfg.az_max            <= AZ_MAX_RESET;
      cfg.az_step           <= AZ_STEP_RESET;
      cfg.el_min            <= '0;
      cfg.el_max            <= EL_MAX_RESET;
      cfg.el_step           <= EL_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWEEP_TYPE: cfg.sweep_type        <= cfg_data[1:0];
        REG_SPP:        cfg.samples_per_point <= cfg_data[7:0];
        REG_AZ_MIN:     cfg.az_min            <= cfg_data;
        REG_AZ_MAX:     cfg.az_max            <= cfg_data;
        REG_AZ_STEP:    cfg.az_step           <= cfg_data[28:0];
        REG_EL_MIN:     cfg.el_min            <= cfg_data;
        REG_EL_MAX:     cfg.el_max            <= cfg_data;
        REG_EL_STEP:    cfg.el_step           <= cfg_data[28:0];
        default: ;
      endcase
    end
  end

  // event input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      ev <= ev_in;
    end
  end

  // sweep state, updated as the held event moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance && in_valid) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid          = out_valid;
  assign m_tuser           = out_res.report;
  assign m_tdata[1:0]      = out_res.az_move;
  assign m_tdata[32:2]     = out_res.az_target;
  assign m_tdata[33]       = out_res.az_clear_swept;
  assign m_tdata[35:34]    = out_res.el_move;
  assign m_tdata[65:36]    = out_res.el_target;
  assign m_tdata[66]       = out_res.el_clear_swept;
  assign m_tdata[98:67]    = out_res.stamp_ms;
  assign m_tdata[106:99]   = out_res.sample_index;
  assign m_tdata[122:107]  = out_res.power_out;
  assign m_tdata[152:123]  = out_res.az_report;
  assign m_tdata[182:153]  = out_res.el_report;
  assign m_tdata[183]      = 1'b0;

endmodule

>>> dv/tb_az_el_measurement_sweep_sequencer.sv
// Self-checking testbench for the az/el sweep sequencer: random and directed events.
`timescale 1ns / 1ps

module tb_az_el_measurement_sweep_sequencer;
  import azel_pkg::*;

  localparam int unsigned PERIOD_MS     = 100;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int          ANGLE_MAX     = 360000000;
  localparam int          SWEPT_MAX     = 720000000;
  localparam int          PHASE_ITEMS   = 75;

  // the same limits at field width
  localparam logic signed [29:0] ANGLE_TOP = 30'sd360000000;
  localparam logic [29:0]        SWEPT_TOP = 30'd720000000;
  localparam logic [28:0]        STEP_TOP  = 29'd360000000;

  // codes the package leaves unnamed
  localparam logic [1:0] KIND_UNUSED     = 2'd3;
  localparam logic [1:0] SWEEP_UNDEFINED = 2'd3;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [167:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [183:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [29:0]  cfg_data;

  az_el_measurement_sweep_sequencer #(.PERIOD_MS(PERIOD_MS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  class sweep_scoreboard;
    cfg_t        regs;
    state_t      st;
    result_t     awaited[$];
    int          errors;
    int unsigned period_ms;

    function new(int unsigned period);
      period_ms              = period;
      regs.sweep_type        = SWEEP_FULL;
      regs.samples_per_point = SPP_RESET;
      regs.az_min            = '0;
      regs.az_max            = AZ_MAX_RESET;
      regs.az_step           = AZ_STEP_RESET;
      regs.el_min            = '0;
      regs.el_max            = EL_MAX_RESET;
      regs.el_step           = EL_STEP_RESET;
      st                     = '0;
      errors                 = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [29:0] d);
      case (idx)
        REG_SWEEP_TYPE: regs.sweep_type = d[1:0];
        REG_SPP:        regs.samples_per_point = d[7:0];
        REG_AZ_MIN:     regs.az_min = d;
        REG_AZ_MAX:     regs.az_max = d;
        REG_AZ_STEP:    regs.az_step = d[28:0];
        REG_EL_MIN:     regs.el_min = d;
        REG_EL_MAX:     regs.el_max = d;
        REG_EL_STEP:    regs.el_step = d[28:0];
        default: ;
      endcase
    endfunction

    // works out the motor commands and report for one accepted event beat
    function void note_event(event_t ev);
      result_t     r;
      logic [31:0] elapsed;
      longint      travel;
      longint      nx;
      bit          do_az;
      bit          do_el;
      bit          finished;
      r        = '0;
      finished = 1'b0;
      case (ev.kind)
        KIND_RESET: begin
          r.az_move   = MOVE_RESET;
          r.el_move   = MOVE_RESET;
          st.az_done  = 1'b0;
          st.el_done  = 1'b0;
          st.all_done = 1'b0;
        end
        KIND_START: begin
          r.az_move        = MOVE_TO;
          r.az_target      = regs.az_min;
          r.az_clear_swept = 1'b1;
          r.el_move        = MOVE_TO;
          r.el_target      = regs.el_max;
          r.el_clear_swept = 1'b1;
          st.last_az       = regs.az_min;
          st.last_el       = regs.el_max;
          st.az_done       = 1'b0;
          st.el_done       = 1'b0;
          st.all_done      = 1'b0;
        end
        KIND_TICK: begin
          elapsed = ev.now_ms - st.last_sample_time;
          if (elapsed < period_ms) return;
          if (st.sample_count >= regs.samples_per_point) begin
            do_az = (regs.sweep_type == SWEEP_FULL) || (regs.sweep_type == SWEEP_AZ);
            do_el = (regs.sweep_type == SWEEP_FULL) || (regs.sweep_type == SWEEP_EL);
            st.sample_count = '0;
            if (do_az) begin
              travel = longint'(regs.az_max) - longint'(regs.az_min);
              if (travel < 0) travel = -travel;
              if (longint'(ev.az_swept) < travel) begin
                nx = longint'(st.last_az) + longint'(regs.az_step);
                if (nx > regs.az_max) nx = regs.az_max;
                r.az_move   = MOVE_TO;
                r.az_target = nx[30:0];
                st.last_az  = nx[29:0];
              end else begin
                // end of azimuth travel: unwind by what was swept
                nx               = -longint'(ev.az_swept);
                r.az_move        = MOVE_BY;
                r.az_target      = nx[30:0];
                r.az_clear_swept = 1'b1;
                st.az_done       = 1'b1;
                st.last_az       = regs.az_min;
              end
            end
            if (do_el && (regs.sweep_type == SWEEP_EL || st.az_done)) begin
              travel = longint'(regs.el_max) - longint'(regs.el_min);
              if (travel < 0) travel = -travel;
              if (longint'(ev.el_swept) < travel) begin
                nx = longint'(st.last_el) - longint'(regs.el_step);
                if (nx < regs.el_min) nx = regs.el_min;
                r.el_move   = MOVE_TO;
                r.el_target = nx[29:0];
                st.last_el  = nx[29:0];
                st.az_done  = 1'b0;
              end else begin
                r.el_move        = MOVE_TO;
                r.el_target      = regs.el_max;
                r.el_clear_swept = 1'b1;
                st.el_done       = 1'b1;
                st.last_el       = regs.el_max;
              end
            end
            // undefined sweep type leaves all_done as it was
            if (regs.sweep_type == SWEEP_FULL) st.all_done = st.el_done && st.az_done;
            else if (regs.sweep_type == SWEEP_AZ) st.all_done = st.az_done;
            else if (regs.sweep_type == SWEEP_EL) st.all_done = st.el_done;
            finished = st.all_done;
          end
          r.stamp_ms = ev.now_ms;
          if (finished) begin
            r.report = REP_DONE;
          end else begin
            st.sample_count     = st.sample_count + 8'd1;
            st.last_sample_time = ev.now_ms;
            r.report            = REP_MEAS;
            r.sample_index      = st.sample_count;
            r.power_out         = ev.power_sample;
            r.az_report         = ev.az_position;
            r.el_report         = ev.el_position;
          end
        end
        default: return;
      endcase
      awaited.push_back(r);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) note_error($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        note_error("result beat with nothing awaited");
        return;
      end
      want = awaited.pop_front();
      check_field("az_move", want.az_move, got.az_move);
      check_field("az_target", want.az_target, got.az_target);
      check_field("az_clear_swept", want.az_clear_swept, got.az_clear_swept);
      check_field("el_move", want.el_move, got.el_move);
      check_field("el_target", want.el_target, got.el_target);
      check_field("el_clear_swept", want.el_clear_swept, got.el_clear_swept);
      check_field("report", want.report, got.report);
      check_field("stamp_ms", want.stamp_ms, got.stamp_ms);
      check_field("sample_index", want.sample_index, got.sample_index);
      check_field("power_out", want.power_out, got.power_out);
      check_field("az_report", want.az_report, got.az_report);
      check_field("el_report", want.el_report, got.el_report);
    endfunction
  endclass

  sweep_scoreboard sb;
  cfg_t            setup;
  logic [31:0]     clock_ms;
  int              recv_wait;
  bit              recv_busy;
  bit              hold_req;
  int unsigned     cycles;

  always #4 clk = ~clk;

  function automatic result_t unpack_result(logic [183:0] d, logic [1:0] u);
    result_t r;
    r.az_move        = d[1:0];
    r.az_target      = d[32:2];
    r.az_clear_swept = d[33];
    r.el_move        = d[35:34];
    r.el_target      = d[65:36];
    r.el_clear_swept = d[66];
    r.stamp_ms       = d[98:67];
    r.sample_index   = d[106:99];
    r.power_out      = d[122:107];
    r.az_report      = d[152:123];
    r.el_report      = d[182:153];
    r.report         = u;
    return r;
  endfunction

  function automatic logic signed [29:0] pick_angle();
    return 30'(int'($urandom_range(0, SWEPT_MAX)) - ANGLE_MAX);
  endfunction

  // mostly short of the travel, now and then at or past it
  function automatic logic [29:0] pick_swept(int travel);
    if ($urandom_range(0, 3) == 0) return 30'($urandom_range(travel, SWEPT_MAX));
    if (travel == 0) return '0;
    return 30'($urandom_range(0, travel - 1));
  endfunction

  function automatic cfg_t pick_setup();
    cfg_t c;
    c.sweep_type        = ($urandom_range(0, 7) == 0) ? SWEEP_UNDEFINED : 2'($urandom_range(0, 2));
    c.samples_per_point = 8'($urandom_range(0, 3));
    c.az_min            = pick_angle();
    c.az_max            = pick_angle();
    c.az_step           = 29'($urandom_range(0, ANGLE_MAX));
    c.el_min            = pick_angle();
    c.el_max            = pick_angle();
    c.el_step           = 29'($urandom_range(0, ANGLE_MAX));
    return c;
  endfunction

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: check each beat, then draw the stall before the next one
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(unpack_result(m_tdata, m_tuser));
      recv_wait = recv_busy ? 0 : $urandom_range(0, 4);
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      recv_wait = HOLD_CYCLES;
    end
    if (recv_wait > 0) begin
      m_tready <= 1'b0;
      recv_wait = recv_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send(input logic [1:0] kind, input logic [31:0] now,
                      input logic signed [15:0] power, input logic [29:0] azsw,
                      input logic [29:0] elsw, input logic signed [29:0] azpos,
                      input logic signed [29:0] elpos, input bit busy);
    event_t ev;
    int     gap;
    ev.kind         = kind;
    ev.now_ms       = now;
    ev.power_sample = power;
    ev.az_swept     = azsw;
    ev.el_swept     = elsw;
    ev.az_position  = azpos;
    ev.el_position  = elpos;
    gap = busy ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= ev.kind;
    s_tdata  <= {ev.el_position, ev.az_position, ev.el_swept, ev.az_swept,
                 ev.power_sample, ev.now_ms};
    do @(posedge clk); while (!s_tready);
    sb.note_event(ev);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    // early ticks and unused kinds leave no result but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [29:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    sb.set_register(idx, d);
  endtask

  task automatic configure(input cfg_t c);
    wait_idle();
    write_reg(REG_SWEEP_TYPE, 30'(c.sweep_type));
    write_reg(REG_SPP, 30'(c.samples_per_point));
    write_reg(REG_AZ_MIN, c.az_min);
    write_reg(REG_AZ_MAX, c.az_max);
    write_reg(REG_AZ_STEP, 30'(c.az_step));
    write_reg(REG_EL_MIN, c.el_min);
    write_reg(REG_EL_MAX, c.el_max);
    write_reg(REG_EL_STEP, 30'(c.el_step));
    @(negedge clk);
    cfg_we <= 1'b0;
    setup = c;
  endtask

  task automatic run_phase(input int count, input bit busy, input bit pause_mid);
    int          taken;
    int          pick;
    int          travel_az;
    int          travel_el;
    logic [1:0]  kind;
    logic [31:0] now;
    taken     = 0;
    travel_az = int'(setup.az_max) - int'(setup.az_min);
    travel_el = int'(setup.el_max) - int'(setup.el_min);
    if (travel_az < 0) travel_az = -travel_az;
    if (travel_el < 0) travel_el = -travel_el;
    while (taken < count) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 3) ? KIND_UNUSED : (pick < 7) ? KIND_RESET :
             (pick < 12) ? KIND_START : KIND_TICK;
      pick = $urandom_range(0, 19);
      if (pick < 3) clock_ms = clock_ms + $urandom_range(0, PERIOD_MS - 1);
      else if (pick == 3) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + PERIOD_MS + $urandom_range(0, 2 * PERIOD_MS);
      now = (kind == KIND_TICK) ? clock_ms : $urandom;
      send(kind, now, 16'($urandom), pick_swept(travel_az), pick_swept(travel_el),
           pick_angle(), pick_angle(), busy);
      if (kind != KIND_UNUSED) taken++;
      if (pause_mid && taken == count / 2) begin
        pause_mid = 1'b0;
        wait_idle();
      end
    end
  endtask

  initial begin
    cfg_t c;
    sb        = new(PERIOD_MS);
    setup     = sb.regs;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    recv_wait = 0;
    recv_busy = 1'b0;
    hold_req  = 1'b0;
    cycles    = 0;
    clock_ms  = $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults: early ticks, ignored kind, a full pointing, wrap of the ms clock
    send(KIND_TICK, 32'd0, 16'sd0, '0, '0, '0, '0, 1'b0);
    send(KIND_TICK, 32'd99, 16'sd0, '0, '0, '0, '0, 1'b0);
    send(KIND_UNUSED, 32'hFFFF_FFFF, 16'sh7FFF, SWEPT_TOP, SWEPT_TOP,
         ANGLE_TOP, ANGLE_TOP, 1'b0);
    send(KIND_TICK, 32'd100, -16'sd32768, '0, '0, -ANGLE_TOP, ANGLE_TOP, 1'b0);
    send(KIND_TICK, 32'd150, 16'sd1, '0, '0, '0, '0, 1'b0);
    for (int i = 2; i <= 5; i++)
      send(KIND_TICK, 32'(100 * i), 16'sh7FFF, 30'd358, 30'd89, ANGLE_TOP, -ANGLE_TOP,
           1'b0);
    send(KIND_TICK, 32'd600, 16'sd1, 30'd358, 30'd89, 30'sd12345, -30'sd12345, 1'b0);
    send(KIND_START, 32'd700, 16'sd0, '0, '0, '0, '0, 1'b0);
    send(KIND_RESET, 32'd800, 16'sd0, '0, '0, '0, '0, 1'b0);
    send(KIND_TICK, 32'hFFFF_FFC0, -16'sd1, '0, '0, '0, '0, 1'b0);
    send(KIND_TICK, 32'h0000_0030, 16'sd2, '0, '0, '0, '0, 1'b0);

    // zero samples per point: every sampling tick moves, run to finished status
    c = setup;
    c.samples_per_point = 8'd0;
    configure(c);
    send(KIND_TICK, 32'd1000, 16'sd256, '0, '0, 30'sd1, 30'sd2, 1'b0);
    send(KIND_TICK, 32'd1100, -16'sd256, SWEPT_TOP, '0, 30'sd3, 30'sd4, 1'b0);
    send(KIND_TICK, 32'd1200, 16'sd0, 30'd359, SWEPT_TOP, 30'sd5, 30'sd6, 1'b0);
    send(KIND_TICK, 32'd1250, 16'sd0, 30'd359, SWEPT_TOP, 30'sd5, 30'sd6, 1'b0);
    send(KIND_START, 32'd1260, 16'sd0, '0, '0, '0, '0, 1'b0);
    send(KIND_TICK, 32'd1400, 16'sd7, 30'd10, 30'd10, 30'sd7, 30'sd8, 1'b0);

    // widest travel and largest steps; receiver stalls long while events keep coming
    c.sweep_type        = SWEEP_FULL;
    c.samples_per_point = 8'd2;
    c.az_min            = -ANGLE_TOP;
    c.az_max            = ANGLE_TOP;
    c.az_step           = STEP_TOP;
    c.el_min            = -ANGLE_TOP;
    c.el_max            = ANGLE_TOP;
    c.el_step           = STEP_TOP;
    configure(c);
    hold_req = 1'b1;
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    // azimuth only, end below start
    c.sweep_type        = SWEEP_AZ;
    c.samples_per_point = 8'd1;
    c.az_min            = 30'sd1000;
    c.az_max            = 30'sd500;
    c.az_step           = 29'd100;
    configure(c);
    recv_busy = 1'b1;
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);
    recv_busy = 1'b0;

    // elevation only, does not wait for azimuth
    c.sweep_type        = SWEEP_EL;
    c.samples_per_point = 8'd0;
    c.el_min            = 30'sd10000000;
    c.el_max            = 30'sd80000000;
    c.el_step           = 29'd7000000;
    configure(c);
    run_phase(PHASE_ITEMS, 1'b0, 1'b1);

    c.sweep_type        = SWEEP_UNDEFINED;
    c.samples_per_point = 8'd3;
    configure(c);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // top of the samples-per-point range, reversed azimuth, zero elevation travel
    c.sweep_type        = SWEEP_FULL;
    c.samples_per_point = 8'd255;
    c.az_min            = ANGLE_TOP;
    c.az_max            = -ANGLE_TOP;
    c.az_step           = '0;
    c.el_min            = '0;
    c.el_max            = '0;
    c.el_step           = '0;
    configure(c);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    c.samples_per_point = 8'd1;
    c.az_min            = 30'sd5;
    c.az_max            = 30'sd5;
    c.az_step           = 29'd3;
    c.el_min            = -30'sd50;
    c.el_max            = 30'sd50;
    c.el_step           = 29'd20;
    configure(c);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    for (int p = 0; p < 4; p++) begin
      configure(pick_setup());
      recv_busy = ($urandom_range(0, 3) == 0);
      run_phase(PHASE_ITEMS, $urandom_range(0, 3) == 0, 1'b0);
    end
    recv_busy = 1'b0;

    wait_idle();
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
